/* rtl/core/prq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prq_pkg
// Shared types and codes for the shift-register priority ready queue.
// ----------------------------------------------------------------------------
package prq_pkg;

  // field widths fixed by the command and result words
  localparam int IdW  = 7;
  localparam int PriW = 8;
  localparam int OccW = 7;

  // command codes
  typedef enum logic [1:0] {
    CMD_ENQ    = 2'd0,
    CMD_POP    = 2'd1,
    CMD_REMOVE = 2'd2
  } cmd_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  // one queue entry
  typedef struct packed {
    logic [IdW-1:0]         id;
    logic signed [PriW-1:0] pri;
  } entry_t;

  // per-cell control from the top level
  typedef struct packed {
    logic enq;    // insert the new entry in sorted place
    logic shift;  // take the entry of the cell above (toward the tail)
  } cell_ctrl_t;

  // per-cell status toward the neighbors and the top level
  typedef struct packed {
    logic valid;  // cell holds an entry
    logic stay;   // entry has priority >= the new entry
    logic hit;    // entry id equals the command id
  } cell_stat_t;

endpackage

/* rtl/core/prq_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prq_cell
// One slot of the sorted queue; compares locally and trades entries with
// its two neighbors.
// ----------------------------------------------------------------------------
module prq_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  prq_pkg::cell_ctrl_t ctrl_i,
  input  prq_pkg::entry_t   new_i,
  input  prq_pkg::cell_stat_t prev_stat_i,
  input  prq_pkg::entry_t   prev_entry_i,
  input  logic              next_valid_i,
  input  prq_pkg::entry_t   next_entry_i,
  output prq_pkg::cell_stat_t stat_o,
  output prq_pkg::entry_t   entry_o
);
  import prq_pkg::*;

  logic   valid_q, valid_d;
  entry_t entry_q, entry_d;
  logic   stay, insert_here, take_prev;

  // local compares against the command word
  assign stay = valid_q && ($signed(entry_q.pri) >= $signed(new_i.pri));
  assign insert_here = prev_stat_i.stay && !stay;
  assign take_prev   = prev_stat_i.valid && !prev_stat_i.stay;

  assign stat_o.valid = valid_q;
  assign stat_o.stay  = stay;
  assign stat_o.hit   = valid_q && (entry_q.id == new_i.id);
  assign entry_o      = entry_q;

  // next entry: insert, push back, or close up toward the head
  always_comb begin
    valid_d = valid_q;
    entry_d = entry_q;
    if (ctrl_i.enq) begin
      valid_d = valid_q || prev_stat_i.valid;
      if (insert_here) begin
        entry_d = new_i;
      end else if (take_prev) begin
        entry_d = prev_entry_i;
      end
    end else if (ctrl_i.shift) begin
      valid_d = next_valid_i;
      entry_d = next_entry_i;
    end
  end

  // occupancy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // entry payload
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

/* rtl/core/priority_ready_queue_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_ready_queue_top
// Sorted priority queue of task ids built as a chain of compare cells.
// ----------------------------------------------------------------------------
// a taken command has its result word registered and shown in the next cycle
// throughput: one command per cycle; every cell compares and moves in parallel
// busy stays low, so start may be held high on consecutive cycles
// each result is shown for one cycle on result_valid_o and cannot be stalled
// reset empties the queue (all cell valid flags and the fill count clear)
module priority_ready_queue_top #(
  parameter int DEPTH = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    cmd_i,
  input  logic signed [prq_pkg::PriW-1:0] priority_req_i,
  input  logic [prq_pkg::IdW-1:0]       task_id_i,
  output logic                          result_valid_o,
  output logic [1:0]                    status_o,
  output logic [prq_pkg::IdW-1:0]       task_out_o,
  output logic [prq_pkg::OccW-1:0]      occupancy_o
);
  import prq_pkg::*;

  localparam int CntRaw = $clog2(DEPTH + 1);
  localparam int CntW   = (CntRaw > OccW) ? CntRaw : OccW;
  localparam int Levels = $clog2(DEPTH);
  localparam logic [CntW-1:0] Full = CntW'(DEPTH);

  logic                accept;
  entry_t              new_entry;
  cell_stat_t          stat   [DEPTH];
  entry_t              entries[DEPTH];
  cell_ctrl_t          ctrl   [DEPTH];
  logic [DEPTH-1:0]    hit_vec;
  logic [DEPTH-1:0]    hit_above;
  logic                any_hit;
  logic                enq_go, pop_go, rm_go;
  logic [CntW-1:0]     count_q, count_d;
  status_e             status_d;
  logic [IdW-1:0]      tout_d;
  logic                rvalid_q;
  status_e             status_q;
  logic [IdW-1:0]      tout_q;

  assign busy      = 1'b0;
  assign accept    = start && !busy;
  assign new_entry = '{id: task_id_i, pri: priority_req_i};

  // chain of cells, head (highest priority) at index 0
  for (genvar j = 0; j < DEPTH; j++) begin : g_cell
    cell_stat_t prev_stat;
    entry_t     prev_entry;
    logic       next_valid;
    entry_t     next_entry;

    if (j == 0) begin : g_head
      assign prev_stat  = '{valid: 1'b1, stay: 1'b1, hit: 1'b0};
      assign prev_entry = '0;
    end else begin : g_body
      assign prev_stat  = stat[j-1];
      assign prev_entry = entries[j-1];
    end

    if (j == DEPTH - 1) begin : g_tail
      assign next_valid = 1'b0;
      assign next_entry = '0;
    end else begin : g_mid
      assign next_valid = stat[j+1].valid;
      assign next_entry = entries[j+1];
    end

    assign hit_vec[j]  = stat[j].hit;
    assign ctrl[j].enq   = enq_go;
    assign ctrl[j].shift = pop_go || (rm_go && !hit_above[j]);

    prq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl[j]),
      .new_i        (new_entry),
      .prev_stat_i  (prev_stat),
      .prev_entry_i (prev_entry),
      .next_valid_i (next_valid),
      .next_entry_i (next_entry),
      .stat_o       (stat[j]),
      .entry_o      (entries[j])
    );
  end

  // suffix or of hits: the match nearest the tail is the one removed
  always_comb begin
    logic [DEPTH-1:0] sfx;
    sfx = hit_vec;
    for (int lv = 0; lv < Levels; lv++) begin
      for (int j = 0; j < DEPTH; j++) begin
        if (j + (1 << lv) < DEPTH) begin
          sfx[j] = sfx[j] | sfx[j + (1 << lv)];
        end
      end
    end
    hit_above = {1'b0, sfx[DEPTH-1:1]};
    any_hit   = sfx[0];
  end

  // command decode
  always_comb begin
    enq_go   = 1'b0;
    pop_go   = 1'b0;
    rm_go    = 1'b0;
    status_d = ST_OK;
    tout_d   = '0;
    count_d  = count_q;
    unique case (cmd_e'(cmd_i))
      CMD_ENQ: begin
        if (count_q == Full) begin
          status_d = ST_FULL;
        end else begin
          enq_go  = accept;
          tout_d  = task_id_i;
          count_d = count_q + 1'b1;
        end
      end
      CMD_POP: begin
        if (count_q == '0) begin
          status_d = ST_EMPTY;
        end else begin
          pop_go  = accept;
          tout_d  = entries[0].id;
          count_d = count_q - 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (count_q == '0) begin
          status_d = ST_EMPTY;
        end else if (!any_hit) begin
          status_d = ST_NOTFOUND;
        end else begin
          rm_go   = accept;
          tout_d  = task_id_i;
          count_d = count_q - 1'b1;
        end
      end
      default: begin
        status_d = ST_NOTFOUND;
      end
    endcase
  end

  // fill count and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      rvalid_q <= accept;
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  // result word
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      tout_q   <= tout_d;
    end
  end

  assign result_valid_o = rvalid_q;
  assign status_o       = status_q;
  assign task_out_o     = tout_q;
  assign occupancy_o    = count_q[OccW-1:0];

endmodule

/* rtl/core/prq_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prq_checker
// Port-level checks on the priority ready queue, bound to the top level.
// ----------------------------------------------------------------------------
module prq_checker #(
  parameter int DEPTH = 64
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start,
  input logic                          busy,
  input logic [1:0]                    cmd_i,
  input logic signed [prq_pkg::PriW-1:0] priority_req_i,
  input logic [prq_pkg::IdW-1:0]       task_id_i,
  input logic                          result_valid_o,
  input logic [1:0]                    status_o,
  input logic [prq_pkg::IdW-1:0]       task_out_o,
  input logic [prq_pkg::OccW-1:0]      occupancy_o
);
  import prq_pkg::*;

  localparam logic [OccW-1:0] FullOcc = OccW'(DEPTH);

  // every accepted word gives a result in the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> result_valid_o)
    else $error("no result after accepted word");

  // no result without an accepted word
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start && !busy) |=> !result_valid_o)
    else $error("result without accepted word");

  // failed commands report id zero
  a_fail_zero_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (status_o != ST_OK)) |-> (task_out_o == '0))
    else $error("nonzero id on failed command");

  // full only on enqueue, with the queue at capacity
  a_full_enq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (status_o == ST_FULL)) |->
      (($past(cmd_i) == CMD_ENQ) && (occupancy_o == FullOcc)))
    else $error("full status out of place");

  // empty status reports a zero count
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (status_o == ST_EMPTY)) |-> (occupancy_o == '0))
    else $error("empty status with entries held");

endmodule

bind priority_ready_queue_top prq_checker #(.DEPTH(DEPTH)) u_prq_checker (.*);
